>>> design/attack_decay_envelope_unit_assert.svh
// Assertion macros shared by the envelope unit RTL.
`ifndef ATTACK_DECAY_ENVELOPE_UNIT_ASSERT_SVH
`define ATTACK_DECAY_ENVELOPE_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define ADE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("envelope unit: invariant violated");

// Antecedent implies consequent in the same cycle.
`define ADE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("envelope unit: implication violated");

// Antecedent implies consequent in the next cycle.
`define ADE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("envelope unit: next-cycle check violated");

`endif

>>> design/ade_pkg.sv
// Types, constants and helpers for the attack-decay envelope unit.
`timescale 1ns / 1ps
`default_nettype none

package ade_pkg;

    localparam int LEVEL_WIDTH = 11;
    localparam int LEVEL_SHIFT = 10;
    localparam int QUOT_WIDTH  = 10;
    localparam int PROD_WIDTH  = 2 * LEVEL_WIDTH;
    localparam int LEN_WIDTH   = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [LEVEL_WIDTH-1:0] UNITY = 11'd1024;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ATTACK_LENGTH    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DECAY_LENGTH     = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INSTRUMENT_LEVEL = 2'd2;

    // Input item codes: a tick asks for one gain, a start arms the voice.
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SCALE
    } ade_state_t;

    typedef enum logic [1:0] {
        STAGE_ATTACK = 2'd0,
        STAGE_DECAY  = 2'd1,
        STAGE_DONE   = 2'd2
    } ade_stage_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ade_div_status_t;

    function automatic logic [LEVEL_WIDTH-1:0] clamp_unity(input logic [LEVEL_WIDTH-1:0] x);
        return (x > UNITY) ? UNITY : x;
    endfunction

endpackage

`default_nettype wire

>>> design/ade_divider.sv
// Radix-2 restoring fraction divider: quotient = floor(dividend * 2^QUOT_WIDTH / divisor).
`timescale 1ns / 1ps
`default_nettype none
`include "attack_decay_envelope_unit_assert.svh"

module ade_divider
    import ade_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [COUNT_WIDTH-1:0] dividend,
    input  wire logic [COUNT_WIDTH-1:0] divisor,
    output logic      [QUOT_WIDTH-1:0]  quotient,
    output ade_div_status_t             status
);

    localparam int STEP_WIDTH = $clog2(QUOT_WIDTH);
    localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(QUOT_WIDTH - 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [STEP_WIDTH-1:0]  step_reg, step_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] divisor_reg, divisor_next;
    logic [QUOT_WIDTH-1:0]  quot_reg, quot_next;

    logic [COUNT_WIDTH:0]   shifted;
    logic [COUNT_WIDTH:0]   diff;
    logic                   take;

    // one shift/compare/subtract per cycle; remainder stays below divisor
    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        diff    = shifted - {1'b0, divisor_reg};
        take    = (divisor_reg != '0) && (shifted >= {1'b0, divisor_reg});
    end

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        quot_next    = quot_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_next     = dividend;
            divisor_next = divisor;
            quot_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = take ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
            quot_next = {quot_reg[QUOT_WIDTH-2:0], take};
            step_next = step_reg + STEP_WIDTH'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        quot_reg    <= quot_next;
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    `ADE_ASSERT_IMPLY(a_done_not_busy, clk, rst_n, done_reg, !busy_reg)
    `ADE_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `ADE_ASSERT_IMPLY(a_rem_below_divisor, clk, rst_n, busy_reg,
        (divisor_reg == '0) || (rem_reg < divisor_reg))

endmodule

`default_nettype wire

>>> design/attack_decay_envelope_unit.sv
// Top level of the linear attack-decay envelope unit for one synth voice.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in      | input     | in_valid/in_stall   | mode, note_level
//  out     | output    | out_valid/out_stall | gain
//  cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// Tick with a note playing: the next transfer waits for the divider, which finds
// the 10 quotient bits one bit/cycle, and then for a pass through the multiplier.
// Start item, or tick on an idle voice: one pass through the multiplier, no divide.
// Reset (rst_n, async, active low) clears the voice and loads the register defaults.
// in_stall is high while an item is in work; a result waits in the output
// register under out_stall, and a new item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "attack_decay_envelope_unit_assert.svh"

module attack_decay_envelope_unit
    import ade_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       mode,
    input  wire logic [LEVEL_WIDTH-1:0]     note_level,
    // output channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic      [LEVEL_WIDTH-1:0]     gain,
    // configuration
    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [LEN_WIDTH-1:0]       cfg_data
);

    // configuration registers
    logic [LEN_WIDTH-1:0]   attack_length_reg;
    logic [LEN_WIDTH-1:0]   decay_length_reg;
    logic [LEVEL_WIDTH-1:0] instrument_level_reg;

    // voice state
    ade_state_t             state_reg, state_next;
    logic                   active_reg, active_next;
    ade_stage_t             stage_reg, stage_next;
    logic [COUNT_WIDTH-1:0] stage_count_reg, stage_count_next;
    logic [COUNT_WIDTH-1:0] stage_length_reg, stage_length_next;
    logic [LEVEL_WIDTH-1:0] voice_level_reg, voice_level_next;

    // shared multiplier operands; scale_start_reg marks a voice-level product
    logic [LEVEL_WIDTH-1:0] mul_a_reg, mul_a_next;
    logic [LEVEL_WIDTH-1:0] mul_b_reg, mul_b_next;
    logic                   scale_start_reg, scale_start_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [LEVEL_WIDTH-1:0] gain_reg, gain_next;

    // datapath
    logic                   in_take;
    logic                   tick_live;
    logic                   out_free;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   wrap;
    ade_stage_t             stage_adv;
    logic [COUNT_WIDTH-1:0] count_upd;
    logic [COUNT_WIDTH-1:0] length_upd;
    ade_stage_t             stage_upd;
    logic [QUOT_WIDTH-1:0]  quotient;
    ade_div_status_t        div_status;
    logic [LEVEL_WIDTH-1:0] ramp;
    logic [PROD_WIDTH-1:0]  product;
    logic [LEVEL_WIDTH-1:0] scaled;

    assign in_take   = in_valid && (state_reg == ST_IDLE);
    assign tick_live = in_take && (mode == MODE_TICK) && active_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // saturating stage step
    always_comb
    begin
        case (stage_reg)
            STAGE_ATTACK: stage_adv = STAGE_DECAY;
            STAGE_DECAY:  stage_adv = STAGE_DONE;
            STAGE_DONE:   stage_adv = STAGE_DONE;
            default:      stage_adv = STAGE_DONE;
        endcase
    end

    // counter advance: on reaching the stage length, clear and load decay length
    always_comb
    begin
        cnt_inc    = stage_count_reg + COUNT_WIDTH'(1);
        wrap       = (cnt_inc >= stage_length_reg);
        count_upd  = wrap ? '0 : cnt_inc;
        length_upd = wrap ? COUNT_WIDTH'(decay_length_reg) : stage_length_reg;
        stage_upd  = wrap ? stage_adv : stage_reg;
    end

    // ramp = count * 1024 / length, computed one bit per cycle
    ade_divider #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tick_live),
        .dividend (count_upd),
        .divisor  (length_upd),
        .quotient (quotient),
        .status   (div_status)
    );

    // quotient is always below 1024: count stays under the stage length
    always_comb
    begin
        case (stage_reg)
            STAGE_ATTACK: ramp = {1'b0, quotient};
            STAGE_DECAY:  ramp = UNITY - {1'b0, quotient};
            default:      ramp = '0;
        endcase
    end

    // single 11x11 multiplier, used for both voice level and gain
    assign product = PROD_WIDTH'(mul_a_reg) * PROD_WIDTH'(mul_b_reg);
    assign scaled  = product[LEVEL_SHIFT +: LEVEL_WIDTH];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = tick_live ? ST_DIVIDE : ST_SCALE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (scale_start_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath register updates
    always_comb
    begin
        active_next       = active_reg;
        stage_next        = stage_reg;
        stage_count_next  = stage_count_reg;
        stage_length_next = stage_length_reg;
        voice_level_next  = voice_level_reg;
        mul_a_next        = mul_a_reg;
        mul_b_next        = mul_b_reg;
        scale_start_next  = scale_start_reg;
        out_valid_next    = out_valid_reg && out_stall;
        gain_next         = gain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (mode == MODE_START)
                    begin
                        // start: arm voice, product gives the voice level
                        active_next       = 1'b1;
                        stage_next        = STAGE_ATTACK;
                        stage_count_next  = '0;
                        stage_length_next = COUNT_WIDTH'(attack_length_reg);
                        mul_a_next        = clamp_unity(instrument_level_reg);
                        mul_b_next        = clamp_unity(note_level);
                        scale_start_next  = 1'b1;
                    end
                    else
                    begin
                        scale_start_next = 1'b0;
                        mul_b_next       = voice_level_reg;
                        mul_a_next       = '0;
                        if (active_reg)
                        begin
                            stage_next        = stage_upd;
                            stage_count_next  = count_upd;
                            stage_length_next = length_upd;
                        end
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    mul_a_next = ramp;
                end
            end
            ST_SCALE:
            begin
                if (scale_start_reg)
                begin
                    voice_level_next = scaled;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    gain_next      = scaled;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_length_reg    <= LEN_WIDTH'(1);
            decay_length_reg     <= LEN_WIDTH'(1);
            instrument_level_reg <= UNITY;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ATTACK_LENGTH:    attack_length_reg    <= cfg_data;
                REG_DECAY_LENGTH:     decay_length_reg     <= cfg_data;
                REG_INSTRUMENT_LEVEL: instrument_level_reg <= cfg_data[LEVEL_WIDTH-1:0];
                default:              attack_length_reg    <= attack_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            active_reg       <= 1'b0;
            stage_reg        <= STAGE_ATTACK;
            stage_count_reg  <= '0;
            stage_length_reg <= '0;
            voice_level_reg  <= '0;
            scale_start_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_reg       <= active_next;
            stage_reg        <= stage_next;
            stage_count_reg  <= stage_count_next;
            stage_length_reg <= stage_length_next;
            voice_level_reg  <= voice_level_next;
            scale_start_reg  <= scale_start_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        gain_reg  <= gain_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign gain      = gain_reg;

    `ADE_ASSERT_ALWAYS(a_level_bounded, clk, rst_n, voice_level_reg <= UNITY)
    `ADE_ASSERT_ALWAYS(a_count_in_stage, clk, rst_n,
        (stage_count_reg == '0) || (stage_count_reg < stage_length_reg))
    `ADE_ASSERT_IMPLY(a_result_from_scale, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg == ST_SCALE))
    `ADE_ASSERT_IMPLY(a_divide_has_unit, clk, rst_n, state_reg == ST_DIVIDE,
        div_status.busy || div_status.done)

endmodule

`default_nettype wire
